// ===== rtl/core/pidsc_pkg.sv =====
// ----------------------------------------------------------------------------
// pidsc_pkg
// Shared constants and types of the speed pid controller: default widths,
// register map and register reset values.
// ----------------------------------------------------------------------------
package pidsc_pkg;

  localparam int VALUE_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF   = 8;

  localparam int CFG_INDEX_WIDTH = 3;

  // register map
  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_KP_GAIN        = 3'd0,
    REG_KI_GAIN        = 3'd1,
    REG_KD_GAIN        = 3'd2,
    REG_OUT_MIN        = 3'd3,
    REG_OUT_MAX        = 3'd4,
    REG_JUMP_THRESHOLD = 3'd5,
    REG_AUTO_MODE      = 3'd6
  } cfg_reg_t;

  // register reset values
  localparam int   KP_GAIN_RESET        = 0;
  localparam int   KI_GAIN_RESET        = 0;
  localparam int   KD_GAIN_RESET        = 0;
  localparam int   OUT_MIN_RESET        = 0;
  localparam int   OUT_MAX_RESET        = 100;
  localparam int   JUMP_THRESHOLD_RESET = 256;
  localparam logic AUTO_MODE_RESET      = 1'b1;

endpackage

// ===== rtl/core/pid_speed_controller.sv =====
// ----------------------------------------------------------------------------
// pid_speed_controller
// Fixed point speed pid controller with derivative on measurement, setpoint
// jump integral reset, output and integral clamping and manual bypass.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                  payload
//  -------   ---------  -------------------------  ---------------------------
//  sample    in         sample_valid/sample_stall  measured, setpoint
//  result    out        result_valid/result_stall  drive, error_value,
//                                                  integral_value, measured_delta
//  config    in         cfg_write                  cfg_index, cfg_data
//
//  one beat per clock unless the result is stalled; input register, then result
//  register; the controller state is updated in the compute stage
//  reset clears valid flags, controller state and registers to defaults
//  sample_stall rises only while a result is held and stalled and the input
//  register is full; the block holds at most two beats in flight
//
module pid_speed_controller
  import pidsc_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst,
  // configuration write port
  input  logic                                    cfg_write,
  input  logic [CFG_INDEX_WIDTH-1:0]              cfg_index,
  input  logic [VALUE_WIDTH-1:0]                  cfg_data,
  // sample channel
  input  logic                                    sample_valid,
  output logic                                    sample_stall,
  input  logic signed [VALUE_WIDTH-1:0]           measured,
  input  logic signed [VALUE_WIDTH-1:0]           setpoint,
  // result channel
  output logic                                    result_valid,
  input  logic                                    result_stall,
  output logic signed [VALUE_WIDTH-1:0]           drive,
  output logic signed [VALUE_WIDTH:0]             error_value,
  output logic signed [VALUE_WIDTH+FRAC_BITS-1:0] integral_value,
  output logic signed [VALUE_WIDTH:0]             measured_delta
);

  localparam int IW = VALUE_WIDTH + FRAC_BITS;

  // configuration
  logic signed [VALUE_WIDTH-1:0] kp_gain;
  logic signed [VALUE_WIDTH-1:0] ki_gain;
  logic signed [VALUE_WIDTH-1:0] kd_gain;
  logic signed [VALUE_WIDTH-1:0] out_min;
  logic signed [VALUE_WIDTH-1:0] out_max;
  logic [VALUE_WIDTH-1:0]        jump_threshold;
  logic                          auto_mode;

  // input register
  logic                          s1_valid;
  logic signed [VALUE_WIDTH-1:0] s1_measured;
  logic signed [VALUE_WIDTH-1:0] s1_setpoint;

  // controller state
  logic signed [IW-1:0]          integral_acc;
  logic signed [VALUE_WIDTH-1:0] prev_measured;
  logic signed [VALUE_WIDTH-1:0] prev_setpoint;
  logic signed [VALUE_WIDTH-1:0] prev_drive;
  logic                          was_automatic;

  // step results
  logic signed [VALUE_WIDTH-1:0] drive_next;
  logic signed [VALUE_WIDTH:0]   error_next;
  logic signed [IW-1:0]          integral_next;
  logic signed [VALUE_WIDTH:0]   delta_next;

  logic result_load;
  logic advance;
  logic sample_take;

  pidsc_cfg_regs #(.VALUE_WIDTH(VALUE_WIDTH)) u_cfg_regs (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .kp_gain        (kp_gain),
    .ki_gain        (ki_gain),
    .kd_gain        (kd_gain),
    .out_min        (out_min),
    .out_max        (out_max),
    .jump_threshold (jump_threshold),
    .auto_mode      (auto_mode)
  );

  pidsc_step #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_step (
    .measured       (s1_measured),
    .setpoint       (s1_setpoint),
    .kp_gain        (kp_gain),
    .ki_gain        (ki_gain),
    .kd_gain        (kd_gain),
    .out_min        (out_min),
    .out_max        (out_max),
    .jump_threshold (jump_threshold),
    .auto_mode      (auto_mode),
    .integral_acc   (integral_acc),
    .prev_measured  (prev_measured),
    .prev_setpoint  (prev_setpoint),
    .prev_drive     (prev_drive),
    .was_automatic  (was_automatic),
    .drive_next     (drive_next),
    .error_next     (error_next),
    .integral_next  (integral_next),
    .delta_next     (delta_next)
  );

  // result register frees up when empty or when its beat is taken
  assign result_load  = !result_valid || !result_stall;
  assign advance      = s1_valid && result_load;
  assign sample_stall = s1_valid && !result_load;
  assign sample_take  = sample_valid && !sample_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      result_valid  <= 1'b0;
      integral_acc  <= '0;
      prev_measured <= '0;
      prev_setpoint <= '0;
      prev_drive    <= '0;
      was_automatic <= 1'b1;
    end else begin
      if (!sample_stall) begin
        s1_valid <= sample_valid;
      end
      if (result_load) begin
        result_valid <= s1_valid;
      end
      // state moves with each beat leaving the compute stage, integral and history only in automatic mode
      if (advance) begin
        was_automatic <= auto_mode;
        if (auto_mode) begin
          integral_acc  <= integral_next;
          prev_measured <= s1_measured;
          prev_setpoint <= s1_setpoint;
          prev_drive    <= drive_next;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (sample_take) begin
      s1_measured <= measured;
      s1_setpoint <= setpoint;
    end
    if (advance) begin
      drive          <= drive_next;
      error_value    <= error_next;
      integral_value <= integral_next;
      measured_delta <= delta_next;
    end
  end

endmodule

// ===== rtl/core/pidsc_clamp.sv =====
// ----------------------------------------------------------------------------
// pidsc_clamp
// Signed limit stage: a value above hi becomes hi, otherwise a value below
// lo becomes lo.
// ----------------------------------------------------------------------------
module pidsc_clamp #(
  parameter int WIDTH = 16
) (
  input  logic signed [WIDTH-1:0] value_in,
  input  logic signed [WIDTH-1:0] lo,
  input  logic signed [WIDTH-1:0] hi,
  output logic signed [WIDTH-1:0] value_out
);

  always_comb begin
    if (value_in > hi) begin
      value_out = hi;
    end else if (value_in < lo) begin
      value_out = lo;
    end else begin
      value_out = value_in;
    end
  end

endmodule

// ===== rtl/core/pidsc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// pidsc_cfg_regs
// Configuration register file: gains, output limits, setpoint jump
// threshold and the automatic mode bit, written through a plain write port.
// ----------------------------------------------------------------------------
module pidsc_cfg_regs
  import pidsc_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [CFG_INDEX_WIDTH-1:0]    cfg_index,
  input  logic [VALUE_WIDTH-1:0]        cfg_data,
  output logic signed [VALUE_WIDTH-1:0] kp_gain,
  output logic signed [VALUE_WIDTH-1:0] ki_gain,
  output logic signed [VALUE_WIDTH-1:0] kd_gain,
  output logic signed [VALUE_WIDTH-1:0] out_min,
  output logic signed [VALUE_WIDTH-1:0] out_max,
  output logic [VALUE_WIDTH-1:0]        jump_threshold,
  output logic                          auto_mode
);

  always_ff @(posedge clk) begin
    if (rst) begin
      kp_gain        <= VALUE_WIDTH'(KP_GAIN_RESET);
      ki_gain        <= VALUE_WIDTH'(KI_GAIN_RESET);
      kd_gain        <= VALUE_WIDTH'(KD_GAIN_RESET);
      out_min        <= VALUE_WIDTH'(OUT_MIN_RESET);
      out_max        <= VALUE_WIDTH'(OUT_MAX_RESET);
      jump_threshold <= VALUE_WIDTH'(JUMP_THRESHOLD_RESET);
      auto_mode      <= AUTO_MODE_RESET;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_KP_GAIN:        kp_gain        <= cfg_data;
        REG_KI_GAIN:        ki_gain        <= cfg_data;
        REG_KD_GAIN:        kd_gain        <= cfg_data;
        REG_OUT_MIN:        out_min        <= cfg_data;
        REG_OUT_MAX:        out_max        <= cfg_data;
        REG_JUMP_THRESHOLD: jump_threshold <= cfg_data;
        REG_AUTO_MODE:      auto_mode      <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/core/pidsc_step.sv =====
// ----------------------------------------------------------------------------
// pidsc_step
// Combinational controller step: error, integral update with jump reset and
// clamp, derivative on measurement, floored and clamped drive, manual bypass.
// ----------------------------------------------------------------------------
module pidsc_step
  import pidsc_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  // item
  input  logic signed [VALUE_WIDTH-1:0]           measured,
  input  logic signed [VALUE_WIDTH-1:0]           setpoint,
  // configuration
  input  logic signed [VALUE_WIDTH-1:0]           kp_gain,
  input  logic signed [VALUE_WIDTH-1:0]           ki_gain,
  input  logic signed [VALUE_WIDTH-1:0]           kd_gain,
  input  logic signed [VALUE_WIDTH-1:0]           out_min,
  input  logic signed [VALUE_WIDTH-1:0]           out_max,
  input  logic [VALUE_WIDTH-1:0]                  jump_threshold,
  input  logic                                    auto_mode,
  // controller state
  input  logic signed [VALUE_WIDTH+FRAC_BITS-1:0] integral_acc,
  input  logic signed [VALUE_WIDTH-1:0]           prev_measured,
  input  logic signed [VALUE_WIDTH-1:0]           prev_setpoint,
  input  logic signed [VALUE_WIDTH-1:0]           prev_drive,
  input  logic                                    was_automatic,
  // result
  output logic signed [VALUE_WIDTH-1:0]           drive_next,
  output logic signed [VALUE_WIDTH:0]             error_next,
  output logic signed [VALUE_WIDTH+FRAC_BITS-1:0] integral_next,
  output logic signed [VALUE_WIDTH:0]             delta_next
);

  localparam int EW = VALUE_WIDTH + 1;
  localparam int PW = 2 * VALUE_WIDTH + 1;
  localparam int IW = VALUE_WIDTH + FRAC_BITS;
  localparam int SW = ((PW > IW) ? PW : IW) + 2;

  logic signed [VALUE_WIDTH-1:0] prev_drive_lim;
  logic signed [IW-1:0]          integral_load;
  logic signed [IW-1:0]          integral_start;
  logic signed [VALUE_WIDTH-1:0] prev_meas_eff;
  logic signed [EW-1:0]          err;
  logic signed [EW-1:0]          jump;
  logic [EW-1:0]                 jump_mag;
  logic                          jump_big;
  logic signed [PW-1:0]          ki_prod;
  logic signed [PW-1:0]          kp_prod;
  logic signed [PW-1:0]          kd_prod;
  logic signed [SW-1:0]          acc_sum;
  logic signed [SW-1:0]          acc_lo;
  logic signed [SW-1:0]          acc_hi;
  logic signed [SW-1:0]          acc_lim;
  logic signed [IW-1:0]          integral_upd;
  logic signed [EW-1:0]          delta;
  logic signed [SW-1:0]          drive_sum;
  logic signed [SW-1:0]          drive_floor;
  logic signed [SW-1:0]          drive_lim;

  // entry into automatic mode: integral restarts from the last automatic drive, clamped
  pidsc_clamp #(.WIDTH(VALUE_WIDTH)) u_prev_clamp (
    .value_in  (prev_drive),
    .lo        (out_min),
    .hi        (out_max),
    .value_out (prev_drive_lim)
  );

  assign integral_load  = IW'(prev_drive_lim) <<< FRAC_BITS;
  assign integral_start = was_automatic ? integral_acc : integral_load;
  assign prev_meas_eff  = was_automatic ? prev_measured : '0;

  assign err      = EW'(setpoint) - EW'(measured);
  assign jump     = EW'(prev_setpoint) - EW'(setpoint);
  assign jump_mag = jump[EW-1] ? EW'(-jump) : EW'(jump);
  assign jump_big = jump_mag > {1'b0, jump_threshold};

  assign ki_prod = PW'(ki_gain) * PW'(err);
  assign acc_sum = SW'(integral_start) + SW'(ki_prod);
  assign acc_lo  = SW'(out_min) <<< FRAC_BITS;
  assign acc_hi  = SW'(out_max) <<< FRAC_BITS;

  pidsc_clamp #(.WIDTH(SW)) u_integral_clamp (
    .value_in  (acc_sum),
    .lo        (acc_lo),
    .hi        (acc_hi),
    .value_out (acc_lim)
  );

  assign integral_upd = jump_big ? '0 : IW'(acc_lim);

  // derivative on measurement
  assign delta   = EW'(measured) - EW'(prev_meas_eff);
  assign kp_prod = PW'(kp_gain) * PW'(err);
  assign kd_prod = PW'(kd_gain) * PW'(delta);

  assign drive_sum   = SW'(kp_prod) + SW'(integral_upd) - SW'(kd_prod);
  assign drive_floor = drive_sum >>> FRAC_BITS;

  pidsc_clamp #(.WIDTH(SW)) u_drive_clamp (
    .value_in  (drive_floor),
    .lo        (SW'(out_min)),
    .hi        (SW'(out_max)),
    .value_out (drive_lim)
  );

  always_comb begin
    if (auto_mode) begin
      drive_next    = VALUE_WIDTH'(drive_lim);
      error_next    = err;
      integral_next = integral_upd;
      delta_next    = delta;
    end else begin
      drive_next    = setpoint;
      error_next    = '0;
      integral_next = integral_acc;
      delta_next    = '0;
    end
  end

endmodule

// ===== rtl/core/pidsc_checker.sv =====
// ----------------------------------------------------------------------------
// pidsc_checker
// Port level checks of the speed pid controller, bound to the top level.
// ----------------------------------------------------------------------------
module pidsc_checker
  import pidsc_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input logic                                    clk,
  input logic                                    rst,
  input logic                                    sample_valid,
  input logic                                    sample_stall,
  input logic                                    result_valid,
  input logic                                    result_stall,
  input logic signed [VALUE_WIDTH-1:0]           drive,
  input logic signed [VALUE_WIDTH:0]             error_value,
  input logic signed [VALUE_WIDTH+FRAC_BITS-1:0] integral_value,
  input logic signed [VALUE_WIDTH:0]             measured_delta
);

  // a stalled result beat holds
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(drive) &&
      $stable(error_value) && $stable(integral_value) && $stable(measured_delta))
    else $error("stalled result beat changed");

  // input side only backs up behind a stalled result
  assert property (@(posedge clk) disable iff (rst)
    sample_stall |-> result_valid && result_stall)
    else $error("sample stall without a stalled result");

  // an accepted beat reaches the result register when the result is not stalled as it leaves the input register
  assert property (@(posedge clk) disable iff (rst)
    (sample_valid && !sample_stall) ##1 !result_stall |=> result_valid)
    else $error("accepted beat did not reach the result");

  // reset empties both stages
  assert property (@(posedge clk)
    rst |=> !result_valid && !sample_stall)
    else $error("pipeline not empty after reset");

endmodule

bind pid_speed_controller pidsc_checker #(
  .VALUE_WIDTH (VALUE_WIDTH),
  .FRAC_BITS   (FRAC_BITS)
) u_pidsc_checker (.*);
